>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous reset that disables it.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication that must hold on every cycle the condition is true.
`define ASSERT_WHEN(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

`endif

>>> sv/lprw_pkg.sv
// ----------------------------------------------------------------------------
// lprw_pkg
// Types and constants of the length-prefixed ring writer.
// ----------------------------------------------------------------------------
package lprw_pkg;

   // Ring geometry
   localparam int RING_BYTES   = 4096;
   localparam int HEADER_BYTES = 2;
   localparam int ADDR_W       = $clog2(RING_BYTES);

   // Field widths
   localparam int LEN_W   = 16;
   localparam int TAIL_W  = 12;
   localparam int DATA_W  = 8;
   localparam int STAT_W  = 3;
   localparam int TOTAL_W = LEN_W + 1;

   // Result queue depth (two words may enter at once)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_ACCEPTED  = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_BUSY      = 3'd3,
      ST_WRITTEN   = 3'd4,
      ST_DROPPED   = 3'd5
   } status_type;

   typedef struct packed {
      logic              operation;
      logic [LEN_W-1:0]  payload_length;
      logic [TAIL_W-1:0] consumer_tail;
      logic [DATA_W-1:0] data_byte;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [DATA_W-1:0] write_data;
      logic              packet_done;
      logic [ADDR_W-1:0] head_pointer;
      logic              last;
   } result_type;

   typedef struct packed {
      logic push;
      logic push_two;
   } push_ctl_type;

endpackage

>>> sv/length_prefixed_ring_writer.sv
// ----------------------------------------------------------------------------
// length_prefixed_ring_writer
// Producer for a byte ring with a 2-byte length header on each packet.
// ----------------------------------------------------------------------------
// One word is accepted per clock unless req_stall is high. A word is held in
// the input register, where it is checked and the ring pointers are updated,
// and then enters a four-entry result queue, whose head drives rsp_. A
// payload byte or a rejected start gives one result word, an accepted start
// gives two (header low, header high), so a stream of payload bytes runs at
// one word per cycle while rsp_stall stays low, and each packet start costs
// one extra output word at the rsp_ port, which is what paces the input.
module length_prefixed_ring_writer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [lprw_pkg::LEN_W-1:0]   req_payload_length,
   input  logic [lprw_pkg::TAIL_W-1:0]  req_consumer_tail,
   input  logic [lprw_pkg::DATA_W-1:0]  req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lprw_pkg::STAT_W-1:0]  rsp_status,
   output logic                         rsp_write_valid,
   output logic [lprw_pkg::ADDR_W-1:0]  rsp_write_address,
   output logic [lprw_pkg::DATA_W-1:0]  rsp_write_data,
   output logic                         rsp_packet_done,
   output logic [lprw_pkg::ADDR_W-1:0]  rsp_head_pointer,
   output logic                         rsp_last
);
   import lprw_pkg::*;

   item_type     in_item;
   push_ctl_type push_ctl;
   result_type   res0, res1, out_res;
   logic         room;

   // Pack the request word
   assign in_item.operation      = req_operation;
   assign in_item.payload_length = req_payload_length;
   assign in_item.consumer_tail  = req_consumer_tail;
   assign in_item.data_byte      = req_data_byte;

   lprw_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_item  (in_item),
      .room     (room),
      .push_ctl (push_ctl),
      .res0     (res0),
      .res1     (res1)
   );

   lprw_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_ctl  (push_ctl),
      .res0      (res0),
      .res1      (res1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   // Unpack the result word
   assign rsp_status        = out_res.status;
   assign rsp_write_valid   = out_res.write_valid;
   assign rsp_write_address = out_res.write_address;
   assign rsp_write_data    = out_res.write_data;
   assign rsp_packet_done   = out_res.packet_done;
   assign rsp_head_pointer  = out_res.head_pointer;
   assign rsp_last          = out_res.last;

endmodule

>>> sv/lprw_core.sv
// ----------------------------------------------------------------------------
// lprw_core
// Input register, packet checks and ring pointer state. Turns one registered
// word into one or two result words per cycle while the queue has room.
// ----------------------------------------------------------------------------
module lprw_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  lprw_pkg::item_type  in_item,
   input  logic                room,
   output lprw_pkg::push_ctl_type push_ctl,
   output lprw_pkg::result_type res0,
   output lprw_pkg::result_type res1
);
   import lprw_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   item_type             item_ff, item_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [ADDR_W-1:0]    wr_ff, wr_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic                 open_ff, open_in;

   logic                 accept, advance;
   logic [TOTAL_W-1:0]   total, space;
   logic [ADDR_W-1:0]    tail, used, a1, a2;
   logic [LEN_W-1:0]     left_dec;
   result_type           blank;

   function automatic logic [ADDR_W-1:0] in_item_tail(input logic [TAIL_W-1:0] t);
      in_item_tail = ADDR_W'(t);
   endfunction

   // Stall only while the held word cannot move on
   assign in_stall = in_valid_ff & ~room;
   assign accept   = in_valid & ~in_stall;
   assign advance  = in_valid_ff & room;

   // Load the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         item_in     = in_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Ring arithmetic on the held word
   assign tail     = in_item_tail(item_ff.consumer_tail);
   assign total    = {1'b0, item_ff.payload_length} + TOTAL_W'(HEADER_BYTES);
   assign used     = head_ff - tail;
   assign space    = TOTAL_W'(RING_BYTES - 1) - {{(TOTAL_W-ADDR_W){1'b0}}, used};
   assign a1       = head_ff + ADDR_W'(1);
   assign a2       = head_ff + ADDR_W'(2);
   assign left_dec = left_ff - LEN_W'(1);

   // Decide results and next pointer state
   always_comb begin
      blank               = '0;
      blank.head_pointer  = head_ff;
      blank.last          = 1'b1;
      res0                = blank;
      res1                = blank;
      push_ctl.push       = advance;
      push_ctl.push_two   = 1'b0;
      head_in             = head_ff;
      wr_in               = wr_ff;
      left_in             = left_ff;
      open_in             = open_ff;

      priority if (item_ff.operation == OP_START && open_ff) begin
         res0.status = ST_BUSY;
      end else if (item_ff.operation == OP_START && total > TOTAL_W'(RING_BYTES)) begin
         res0.status = ST_TOO_LARGE;
      end else if (item_ff.operation == OP_START && space < total) begin
         res0.status = ST_NO_SPACE;
      end else if (item_ff.operation == OP_START) begin
         // Accept: two header bytes, little-endian
         push_ctl.push_two   = advance;
         res0.status         = ST_ACCEPTED;
         res0.write_valid    = 1'b1;
         res0.write_address  = head_ff;
         res0.write_data     = item_ff.payload_length[DATA_W-1:0];
         res0.last           = 1'b0;
         res1.status         = ST_ACCEPTED;
         res1.write_valid    = 1'b1;
         res1.write_address  = a1;
         res1.write_data     = item_ff.payload_length[LEN_W-1:DATA_W];
         wr_in               = a2;
         left_in             = item_ff.payload_length;
         if (item_ff.payload_length == '0) begin
            res1.packet_done  = 1'b1;
            res1.head_pointer = a2;
            head_in           = a2;
         end else begin
            open_in = 1'b1;
         end
      end else if (!open_ff) begin
         res0.status = ST_DROPPED;
      end else begin
         // Payload byte into the ring
         res0.status        = ST_WRITTEN;
         res0.write_valid   = 1'b1;
         res0.write_address = wr_ff;
         res0.write_data    = item_ff.data_byte;
         wr_in              = wr_ff + ADDR_W'(1);
         left_in            = left_dec;
         if (left_dec == '0) begin
            res0.packet_done  = 1'b1;
            res0.head_pointer = wr_ff + ADDR_W'(1);
            head_in           = wr_ff + ADDR_W'(1);
            open_in           = 1'b0;
         end
      end
   end

   // Hold the input word
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Commit pointer state when the word moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         wr_ff   <= '0;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else if (advance) begin
         head_ff <= head_in;
         wr_ff   <= wr_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

>>> sv/lprw_out_queue.sv
// ----------------------------------------------------------------------------
// lprw_out_queue
// Small result queue: takes one or two words per cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module lprw_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  lprw_pkg::push_ctl_type push_ctl,
   input  lprw_pkg::result_type   res0,
   input  lprw_pkg::result_type   res1,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_stall,
   output lprw_pkg::result_type   out_res
);
   import lprw_pkg::*;

   result_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               pop;
   logic [QCNT_W-1:0]  n_push;

   assign room      = cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign out_res   = mem_ff[rd_ff];
   assign pop       = out_valid & ~out_stall;

   // Advance pointers and count
   always_comb begin
      n_push = '0;
      if (push_ctl.push) begin
         n_push = push_ctl.push_two ? QCNT_W'(2) : QCNT_W'(1);
      end
      wr_in  = wr_ff + n_push[QPTR_W-1:0];
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + n_push - QCNT_W'(pop);
   end

   // Write the storage
   always_ff @(posedge clock) begin
      if (push_ctl.push) begin
         mem_ff[wr_ff] <= res0;
         if (push_ctl.push_two) begin
            mem_ff[wr_ff + QPTR_W'(1)] <= res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> sv/lprw_checker.sv
// ----------------------------------------------------------------------------
// lprw_checker
// Port-level checks of the ring writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lprw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_operation,
   input logic [lprw_pkg::LEN_W-1:0]   req_payload_length,
   input logic [lprw_pkg::TAIL_W-1:0]  req_consumer_tail,
   input logic [lprw_pkg::DATA_W-1:0]  req_data_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [lprw_pkg::STAT_W-1:0]  rsp_status,
   input logic                         rsp_write_valid,
   input logic [lprw_pkg::ADDR_W-1:0]  rsp_write_address,
   input logic [lprw_pkg::DATA_W-1:0]  rsp_write_data,
   input logic                         rsp_packet_done,
   input logic [lprw_pkg::ADDR_W-1:0]  rsp_head_pointer,
   input logic                         rsp_last
);
   import lprw_pkg::*;

   // A stalled result word stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")

   // A word without a ring write carries zero address and data
   `ASSERT_WHEN(a_idle_zero, clock, reset, rsp_valid && !rsp_write_valid, rsp_write_address == '0 && rsp_write_data == '0, "idle write fields not zero")

   // Completion is only reported together with a ring write
   `ASSERT_WHEN(a_done_write, clock, reset, rsp_valid && rsp_packet_done, rsp_write_valid, "done without write")

   // Only the first header byte of an accepted start is not a final word
   `ASSERT_WHEN(a_not_last, clock, reset, rsp_valid && !rsp_last, rsp_status == ST_ACCEPTED && rsp_write_valid && !rsp_packet_done, "bad non-final word")

endmodule

bind length_prefixed_ring_writer lprw_checker u_lprw_checker (.*);

>>> tb/tb_length_prefixed_ring_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_ring_writer
// Self-checking bench for the length-prefixed ring writer.
// ----------------------------------------------------------------------------
// A short table of directed words covers stray bytes, empty packets, oversize
// and full-ring rejects, exact-fit space and busy starts. Random packets
// follow: mostly well-formed start/payload sequences, with busy starts, stray
// bytes and rejects mixed in; near the ring end the length is steered so the
// next header lands across it. Every result word is checked field by field
// against a local model of the ring pointers. Sender bursts, receiver stall
// patterns, a long receiver hold-off and a full drain pause shake the
// handshakes.
// ----------------------------------------------------------------------------
module tb_length_prefixed_ring_writer;
   import lprw_pkg::*;

   localparam int RAND_ITEMS  = 1900;
   localparam int HOLD_LEN    = 400;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DIR_ROWS    = 20;
   localparam int RING_MASK   = RING_BYTES - 1;

   typedef struct packed {
      logic              op;
      logic [LEN_W-1:0]  len;
      logic [TAIL_W-1:0] tail;
      logic [DATA_W-1:0] dbyte;
      logic              typed;
      status_type        exp_st;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_operation;
   logic [LEN_W-1:0]    req_payload_length;
   logic [TAIL_W-1:0]   req_consumer_tail;
   logic [DATA_W-1:0]   req_data_byte;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_write_valid;
   logic [ADDR_W-1:0]   rsp_write_address;
   logic [DATA_W-1:0]   rsp_write_data;
   logic                rsp_packet_done;
   logic [ADDR_W-1:0]   rsp_head_pointer;
   logic                rsp_last;

   // Ring pointer model
   logic [ADDR_W-1:0]   ring_head;
   logic [ADDR_W-1:0]   ring_wr_off;
   logic [LEN_W-1:0]    ring_bytes_due;
   logic                ring_pkt_open;

   result_type          due_words [$];
   int                  mismatches;
   int                  words_seen;
   int                  cycle_count;

   // Receiver pattern state
   logic                hold_go;
   int                  hold_cycles;
   int                  pat_left;
   int                  pat_stall;
   int                  pat_go;

   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{OP_BYTE,  16'h0000, 12'h000, 8'hFF, 1'b1, ST_DROPPED},   // stray byte after reset
      '{OP_START, 16'h0000, 12'h000, 8'h00, 1'b1, ST_ACCEPTED},  // empty packet
      '{OP_START, 16'hFFFF, 12'hFFF, 8'h00, 1'b1, ST_TOO_LARGE},
      '{OP_START, 16'd4095, 12'h002, 8'h00, 1'b1, ST_TOO_LARGE}, // one over the ring
      '{OP_START, 16'd4094, 12'h002, 8'h00, 1'b1, ST_NO_SPACE},  // fits ring, not free space
      '{OP_START, 16'h0000, 12'h003, 8'h00, 1'b1, ST_NO_SPACE},  // ring full
      '{OP_START, 16'h0000, 12'h005, 8'h00, 1'b0, ST_ACCEPTED},  // exact fit
      '{OP_START, 16'h0001, 12'h007, 8'h00, 1'b0, ST_ACCEPTED},  // one short
      '{OP_START, 16'h0001, 12'h008, 8'h00, 1'b0, ST_ACCEPTED},
      '{OP_START, 16'h0000, 12'h000, 8'h00, 1'b1, ST_BUSY},
      '{OP_BYTE,  16'hFFFF, 12'hFFF, 8'h00, 1'b0, ST_ACCEPTED},
      '{OP_START, 16'h0002, 12'hFFF, 8'h00, 1'b0, ST_ACCEPTED},
      '{OP_BYTE,  16'h0000, 12'h000, 8'h80, 1'b0, ST_ACCEPTED},
      '{OP_BYTE,  16'h0000, 12'h000, 8'h7F, 1'b0, ST_ACCEPTED},
      '{OP_START, 16'h0003, 12'h00B, 8'h00, 1'b0, ST_ACCEPTED},
      '{OP_BYTE,  16'h0000, 12'h000, 8'hAA, 1'b0, ST_ACCEPTED},
      '{OP_START, 16'h0009, 12'h000, 8'h00, 1'b1, ST_BUSY},
      '{OP_BYTE,  16'h0000, 12'h000, 8'h55, 1'b0, ST_ACCEPTED},
      '{OP_BYTE,  16'h0000, 12'h000, 8'hFF, 1'b0, ST_ACCEPTED},
      '{OP_BYTE,  16'h0000, 12'h000, 8'h01, 1'b1, ST_DROPPED}
   };

   length_prefixed_ring_writer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_payload_length (req_payload_length),
      .req_consumer_tail  (req_consumer_tail),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_data     (rsp_write_data),
      .rsp_packet_done    (rsp_packet_done),
      .rsp_head_pointer   (rsp_head_pointer),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Build one result word; head_pointer is the head as it stands now
   function automatic result_type ring_word(input status_type st, input logic wv,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] wdata,
                                            input logic done, input logic fin);
      result_type w;
      w.status        = st;
      w.write_valid   = wv;
      w.write_address = wv ? addr : '0;
      w.write_data    = wv ? wdata : '0;
      w.packet_done   = done;
      w.head_pointer  = ring_head;
      w.last          = fin;
      return w;
   endfunction

   // Advance the ring pointers by one word and return the result words it causes
   function automatic int predict_ring_words(input logic op, input logic [LEN_W-1:0] len,
                                             input logic [TAIL_W-1:0] tail,
                                             input logic [DATA_W-1:0] dbyte,
                                             output result_type words [2]);
      int                total;
      int                space;
      logic [ADDR_W-1:0] used;
      logic [ADDR_W-1:0] a0;
      logic [ADDR_W-1:0] a1;
      total = int'(len) + HEADER_BYTES;
      used  = ring_head - ADDR_W'(tail);
      space = RING_BYTES - 1 - int'(used);
      words[1] = '0;
      if (op == OP_START) begin
         if (ring_pkt_open) begin
            words[0] = ring_word(ST_BUSY, 1'b0, '0, '0, 1'b0, 1'b1);
            return 1;
         end
         if (total > RING_BYTES) begin
            words[0] = ring_word(ST_TOO_LARGE, 1'b0, '0, '0, 1'b0, 1'b1);
            return 1;
         end
         if (space < total) begin
            words[0] = ring_word(ST_NO_SPACE, 1'b0, '0, '0, 1'b0, 1'b1);
            return 1;
         end
         // Header: low byte at head, high byte at head+1, both wrapping
         a0 = ring_head;
         a1 = a0 + 1'b1;
         words[0] = ring_word(ST_ACCEPTED, 1'b1, a0, len[7:0], 1'b0, 1'b0);
         ring_wr_off    = a1 + 1'b1;
         ring_bytes_due = len;
         ring_pkt_open  = (len != 0);
         if (len == 0) ring_head = ring_wr_off;
         words[1] = ring_word(ST_ACCEPTED, 1'b1, a1, len[15:8], len == 0, 1'b1);
         return 2;
      end
      if (!ring_pkt_open) begin
         words[0] = ring_word(ST_DROPPED, 1'b0, '0, '0, 1'b0, 1'b1);
         return 1;
      end
      // Payload byte: write, advance, publish the head on the last one
      a0 = ring_wr_off;
      ring_wr_off    = ring_wr_off + 1'b1;
      ring_bytes_due = ring_bytes_due - 1'b1;
      if (ring_bytes_due == 0) begin
         ring_head     = ring_wr_off;
         ring_pkt_open = 1'b0;
      end
      words[0] = ring_word(ST_WRITTEN, 1'b1, a0, dbyte, ring_bytes_due == 0, 1'b1);
      return 1;
   endfunction

   // Offer one word, hold it until accepted, then queue its expected results
   task automatic send_word(input logic op, input logic [LEN_W-1:0] len,
                            input logic [TAIL_W-1:0] tail, input logic [DATA_W-1:0] dbyte,
                            input logic typed, input status_type typed_st);
      result_type words [2];
      int         n;
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_payload_length <= len;
      req_consumer_tail  <= tail;
      req_data_byte      <= dbyte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = predict_ring_words(op, len, tail, dbyte, words);
      for (int k = 0; k < n; k++) begin
         if (typed) words[k].status = typed_st;
         due_words.push_back(words[k]);
      end
   endtask

   task automatic check_field(input string name, input int exp_val, input int got_val);
      if (exp_val != got_val) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0h got %0h", words_seen, name, exp_val,
                     got_val);
      end
   endtask

   // Compare each accepted result word with the oldest expectation
   task automatic check_rsp_word();
      result_type w;
      if (due_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: unexpected word, status %0h addr %0h", words_seen,
                     rsp_status, rsp_write_address);
      end else begin
         w = due_words.pop_front();
         check_field("status", int'(w.status), int'(rsp_status));
         check_field("write_valid", int'(w.write_valid), int'(rsp_write_valid));
         check_field("write_address", int'(w.write_address), int'(rsp_write_address));
         check_field("write_data", int'(w.write_data), int'(rsp_write_data));
         check_field("packet_done", int'(w.packet_done), int'(rsp_packet_done));
         check_field("head_pointer", int'(w.head_pointer), int'(rsp_head_pointer));
         check_field("last", int'(w.last), int'(rsp_last));
      end
      words_seen++;
   endtask

   // Receiver: check on handshake, then pick the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_rsp_word();
      if (hold_go && hold_cycles < HOLD_LEN) begin
         hold_cycles++;
         rsp_stall <= 1'b1;
      end else begin
         if (pat_left == 0) begin
            pat_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            pat_go    = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                    : $urandom_range(1, 8);
            pat_left  = pat_stall + pat_go;
         end
         rsp_stall <= (pat_left > pat_go);
         pat_left--;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_length_prefixed_ring_writer NOT OK");
         $finish;
      end
   end

   initial begin
      int                rand_items;
      int                burst_left;
      int                sel;
      int                total;
      logic              op;
      logic [LEN_W-1:0]  len;
      logic [TAIL_W-1:0] tail;
      logic [DATA_W-1:0] dbyte;

      ring_head      = '0;
      ring_wr_off    = '0;
      ring_bytes_due = '0;
      ring_pkt_open  = 1'b0;
      mismatches     = 0;
      words_seen     = 0;
      cycle_count    = 0;
      hold_cycles    = 0;
      pat_left       = 0;
      pat_stall      = 0;
      pat_go         = 0;
      rand_items     = 0;
      burst_left     = 0;

      reset              <= 1'b1;
      hold_go            <= 1'b0;
      req_valid          <= 1'b0;
      req_operation      <= OP_START;
      req_payload_length <= '0;
      req_consumer_tail  <= '0;
      req_data_byte      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int r = 0; r < DIR_ROWS; r++)
         send_word(dir_rows[r].op, dir_rows[r].len, dir_rows[r].tail, dir_rows[r].dbyte,
                   dir_rows[r].typed, dir_rows[r].exp_st);

      // Random packets
      while (rand_items < RAND_ITEMS) begin
         len   = LEN_W'($urandom);
         tail  = TAIL_W'($urandom);
         dbyte = DATA_W'($urandom);
         if (ring_pkt_open) begin
            // Payload, with an occasional start that must be refused as busy
            op = ($urandom_range(0, 99) < 4) ? OP_START : OP_BYTE;
         end else if ($urandom_range(0, 99) < 6) begin
            op = OP_BYTE;
         end else begin
            op  = OP_START;
            sel = $urandom_range(0, 99);
            if (int'(ring_head) <= RING_MASK - 2 && RING_MASK - 2 - int'(ring_head) <= 600
                && sel < 50)
               len = LEN_W'(RING_MASK - 2 - int'(ring_head));  // next header at ring end
            else if (sel < 5)  len = '0;
            else if (sel < 40) len = LEN_W'($urandom_range(1, 8));
            else if (sel < 70) len = LEN_W'($urandom_range(9, 64));
            else if (sel < 90) len = LEN_W'($urandom_range(65, 400));
            else if (sel < 94) len = LEN_W'($urandom_range(401, 1500));
            else if (sel < 96) len = LEN_W'($urandom_range(1501, RING_BYTES - 3));
            else               len = LEN_W'($urandom_range(RING_BYTES - 2, 65535));
            // Tail: empty ring, exact fit, one short, or anywhere
            total = int'(len) + HEADER_BYTES;
            sel   = $urandom_range(0, 99);
            if (sel < 60)      tail = ring_head;
            else if (sel < 70) tail = ring_head + TAIL_W'(total + 1);
            else if (sel < 80) tail = ring_head + TAIL_W'(total);
         end
         send_word(op, len, tail, dbyte, 1'b0, ST_ACCEPTED);
         rand_items++;

         // Long receiver hold-off while the sender keeps offering words
         if (rand_items == 300) hold_go <= 1'b1;

         // Pause the sender until every result is back
         if (rand_items == 900) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (due_words.size() != 0) @(posedge clock);
         end else if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end

      // Drain, then let the pipeline settle
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_length_prefixed_ring_writer OK");
      end else begin
         $display("tb_length_prefixed_ring_writer NOT OK");
      end
      $finish;
   end

endmodule
